/* hdl/sckq_pkg.sv */
// Shared types, constants and scancode lookup for the scancode key queue.
package sckq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int CMDQ_DEPTH      = 2;

    localparam logic [7:0] SC_EXTENDED = 8'hE0;
    localparam logic [7:0] SC_PAUSE    = 8'hE1;
    localparam logic [6:0] SC_CODE_MASK = 7'h7F;
    localparam logic [7:0] SC_RELEASE  = 8'h80;
    localparam logic [6:0] SC_UP       = 7'h48;
    localparam logic [6:0] SC_DOWN     = 7'h50;
    localparam logic [6:0] SC_LEFT     = 7'h4B;
    localparam logic [6:0] SC_RIGHT    = 7'h4D;

    localparam logic [6:0] CH_UP    = 7'd1;
    localparam logic [6:0] CH_DOWN  = 7'd2;
    localparam logic [6:0] CH_LEFT  = 7'd3;
    localparam logic [6:0] CH_RIGHT = 7'd4;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_READ = 1'b1
    } opcode_t;

    typedef struct packed {
        opcode_t    opcode;
        logic [7:0] scan_byte;
    } key_req_t;

    typedef struct packed {
        logic       key_valid;
        logic [6:0] key_code;
        logic [6:0] key_char;
        logic       key_down;
        logic       more_keys;
    } key_rsp_t;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_READ = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        logic [6:0] key_char;
        logic [6:0] key_code;
    } key_entry_t;

    typedef struct packed {
        cmd_kind_t  kind;
        key_entry_t entry;
    } queue_cmd_t;

    function automatic logic [6:0] ascii_lookup(input logic [6:0] code);
        logic [6:0] ch;
        unique case (code)
            7'd1:    ch = 7'h1B;
            7'd2:    ch = 7'h31;
            7'd3:    ch = 7'h32;
            7'd4:    ch = 7'h33;
            7'd5:    ch = 7'h34;
            7'd6:    ch = 7'h35;
            7'd7:    ch = 7'h36;
            7'd8:    ch = 7'h37;
            7'd9:    ch = 7'h38;
            7'd10:   ch = 7'h39;
            7'd11:   ch = 7'h30;
            7'd12:   ch = 7'h2D;
            7'd13:   ch = 7'h3D;
            7'd14:   ch = 7'h08;
            7'd15:   ch = 7'h09;
            7'd16:   ch = 7'h71;
            7'd17:   ch = 7'h77;
            7'd18:   ch = 7'h65;
            7'd19:   ch = 7'h72;
            7'd20:   ch = 7'h74;
            7'd21:   ch = 7'h79;
            7'd22:   ch = 7'h75;
            7'd23:   ch = 7'h69;
            7'd24:   ch = 7'h6F;
            7'd25:   ch = 7'h70;
            7'd26:   ch = 7'h5B;
            7'd27:   ch = 7'h5D;
            7'd28:   ch = 7'h0A;
            7'd30:   ch = 7'h61;
            7'd31:   ch = 7'h73;
            7'd32:   ch = 7'h64;
            7'd33:   ch = 7'h66;
            7'd34:   ch = 7'h67;
            7'd35:   ch = 7'h68;
            7'd36:   ch = 7'h6A;
            7'd37:   ch = 7'h6B;
            7'd38:   ch = 7'h6C;
            7'd39:   ch = 7'h3B;
            7'd40:   ch = 7'h27;
            7'd41:   ch = 7'h60;
            7'd43:   ch = 7'h5C;
            7'd44:   ch = 7'h7A;
            7'd45:   ch = 7'h78;
            7'd46:   ch = 7'h63;
            7'd47:   ch = 7'h76;
            7'd48:   ch = 7'h62;
            7'd49:   ch = 7'h6E;
            7'd50:   ch = 7'h6D;
            7'd51:   ch = 7'h2C;
            7'd52:   ch = 7'h2E;
            7'd53:   ch = 7'h2F;
            7'd55:   ch = 7'h2A;
            7'd57:   ch = 7'h20;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

endpackage

/* hdl/sckq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sckq_ram
    #(
        parameter int WIDTH = 14,
        parameter int DEPTH = 16,
        localparam int ADDR_W = $clog2(DEPTH)
    )
    (
        input  logic              clk,
        input  logic              we,
        input  logic [ADDR_W-1:0] waddr,
        input  logic [WIDTH-1:0]  wdata,
        input  logic              re,
        input  logic [ADDR_W-1:0] raddr,
        output logic [WIDTH-1:0]  rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/sckq_front.sv */
// Front end: accepts beats, tracks the extended prefix and classifies keys.
module sckq_front
    import sckq_pkg::*;
    (
        input  logic       clk,
        input  logic       rst_n,
        input  logic       start,
        input  key_req_t   cmd,
        input  logic       full,
        output logic       busy,
        output logic       push,
        output queue_cmd_t push_cmd
    );

    logic       ext_reg;
    logic       ext_next;
    logic       accept;
    logic       is_ext;
    logic       is_pause;
    logic       is_release;
    logic [6:0] code;
    logic [6:0] ch;
    logic [6:0] arrow_ch;

    assign busy       = full;
    assign accept     = start && !busy;
    assign is_ext     = (cmd.scan_byte == SC_EXTENDED);
    assign is_pause   = (cmd.scan_byte == SC_PAUSE);
    assign is_release = ((cmd.scan_byte & SC_RELEASE) != 8'h00);
    assign code       = cmd.scan_byte[6:0] & SC_CODE_MASK;

    always_comb
    begin
        unique case (code)
            SC_UP:    arrow_ch = CH_UP;
            SC_DOWN:  arrow_ch = CH_DOWN;
            SC_LEFT:  arrow_ch = CH_LEFT;
            SC_RIGHT: arrow_ch = CH_RIGHT;
            default:  arrow_ch = 7'd0;
        endcase
    end

    assign ch = ext_reg ? arrow_ch : ascii_lookup(code);

    always_comb
    begin
        ext_next = ext_reg;
        push     = 1'b0;
        push_cmd = '{kind: CMD_READ, entry: '{key_char: ch, key_code: code}};
        if (accept)
        begin
            if (cmd.opcode == OP_READ)
            begin
                push = 1'b1;
            end
            else
            begin
                ext_next      = is_ext;
                push_cmd.kind = CMD_PUSH;
                push          = !is_ext && !is_pause && !is_release && (ch != 7'd0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg <= 1'b0;
        end
        else
        begin
            ext_reg <= ext_next;
        end
    end

endmodule

/* hdl/sckq_cmdq.sv */
// Short command queue between the front end and the key store back end.
module sckq_cmdq
    import sckq_pkg::*;
    (
        input  logic       clk,
        input  logic       rst_n,
        input  logic       push,
        input  queue_cmd_t push_cmd,
        output logic       full,
        input  logic       pop,
        output logic       pop_valid,
        output queue_cmd_t pop_cmd
    );

    localparam int PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

    queue_cmd_t       slot_reg [CMDQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(CMDQ_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hdl/sckq_back.sv */
// Back end: ring queue of keys in RAM, pushes and reads with result register.
module sckq_back
    import sckq_pkg::*;
    #(
        parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
    )
    (
        input  logic       clk,
        input  logic       rst_n,
        input  logic       cmd_valid,
        input  queue_cmd_t cmd,
        output logic       cmd_pop,
        output logic       done,
        output key_rsp_t   result
    );

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int KEY_W = $bits(key_entry_t);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [PTR_W-1:0] wp_reg;
    logic [PTR_W-1:0] wp_next;
    logic [PTR_W-1:0] rp_reg;
    logic [PTR_W-1:0] rp_next;
    logic [PTR_W-1:0] wp_inc;
    logic [PTR_W-1:0] rp_inc;
    logic             valid_reg;
    logic             valid_next;
    logic             more_reg;
    logic             more_next;
    logic             done_reg;
    logic             done_next;
    key_rsp_t         result_reg;
    key_rsp_t         result_next;
    logic             ram_we;
    logic             ram_re;
    logic             empty;
    logic             full;
    key_entry_t       rd_entry;
    logic [KEY_W-1:0] ram_rdata;

    assign wp_inc   = (wp_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign rp_inc   = (rp_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
    assign empty    = (wp_reg == rp_reg);
    assign full     = (wp_inc == rp_reg);
    assign rd_entry = key_entry_t'(ram_rdata);

    always_comb
    begin
        state_next  = state_reg;
        wp_next     = wp_reg;
        rp_next     = rp_reg;
        valid_next  = valid_reg;
        more_next   = more_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        cmd_pop     = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.kind == CMD_PUSH)
                    begin
                        if (!full)
                        begin
                            ram_we  = 1'b1;
                            wp_next = wp_inc;
                        end
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        valid_next = !empty;
                        if (!empty)
                        begin
                            rp_next   = rp_inc;
                            more_next = (wp_reg != rp_inc);
                        end
                        else
                        begin
                            more_next = 1'b0;
                        end
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                done_next             = 1'b1;
                result_next.key_valid = valid_reg;
                result_next.key_code  = valid_reg ? rd_entry.key_code : 7'd0;
                result_next.key_char  = valid_reg ? rd_entry.key_char : 7'd0;
                result_next.key_down  = valid_reg;
                result_next.more_keys = more_reg;
                state_next            = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    sckq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (KEY_W'(cmd.entry)),
        .re    (ram_re),
        .raddr (rp_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        valid_reg  <= valid_next;
        more_reg   <= more_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wp_reg    <= '0;
            rp_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            done_reg  <= done_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* hdl/scancode_to_key_queue.sv */
// Scancode set 1 decoder feeding a ring queue of keys; top level.
// An accepted read beat passes the command queue, the read state and the done register.
// The back end writes a key from idle; a read also passes its read state (RAM read port);
// a two-entry command queue lets bytes enter one per cycle until it fills.
// Reset clears pointers, the extended flag and the command queue at once;
// key store contents stay undefined, no clearing pass. Results cannot be stalled.
module scancode_to_key_queue
    import sckq_pkg::*;
    #(
        parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
    )
    (
        input  logic     clk,
        input  logic     rst_n,
        input  logic     start,
        input  key_req_t cmd,
        output logic     busy,
        output logic     done,
        output key_rsp_t result
    );

    queue_cmd_t push_cmd;
    queue_cmd_t pop_cmd;
    logic       cmdq_push;
    logic       cmdq_full;
    logic       pop_valid;
    logic       pop;

    sckq_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd),
        .full     (cmdq_full),
        .busy     (busy),
        .push     (cmdq_push),
        .push_cmd (push_cmd)
    );

    sckq_cmdq u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmdq_push),
        .push_cmd  (push_cmd),
        .full      (cmdq_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_cmd   (pop_cmd)
    );

    sckq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (pop_valid),
        .cmd       (pop_cmd),
        .cmd_pop   (pop),
        .done      (done),
        .result    (result)
    );

endmodule

/* tb/sv/tb_scancode_to_key_queue.sv */
// Testbench for scancode_to_key_queue: a predictor of decoder and key queue checks every read beat.
module tb_scancode_to_key_queue
    import sckq_pkg::*;
    ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_SLOTS   = QUEUE_DEPTH_DEF;
    localparam int MAP_LEN     = 58;
    localparam int LIMIT_NS    = 3_000_000;
    localparam int TAIL_CYCLES = 10;

    localparam logic [0:MAP_LEN-1][7:0] ASCII_MAP = {
        8'd0, 8'd27, "1234567890-=", 8'd8,
        8'd9, "qwertyuiop[]", 8'd10,
        8'd0, "asdfghjkl;", 8'd39, 8'd96,
        8'd0, 8'd92, "zxcvbnm,./",
        8'd0, "*", 8'd0, " "
    };

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    key_req_t cmd = '0;
    logic     busy;
    logic     done;
    key_rsp_t result;

    logic [14:0] key_ring [KEY_SLOTS];
    int          ring_wr;
    int          ring_rd;
    logic        ext_armed;
    key_rsp_t    expected_keys [$];
    int          error_count;
    int          beats_sent;
    bit          gaps_on;

    scancode_to_key_queue dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always #6 clk = ~clk;

    initial
    begin
        #(LIMIT_NS);
        $display("FAIL");
        $finish;
    end

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch %s: got %0h, expected %0h at %0t", field, got, want, $realtime);
        error_count++;
    endtask

    function automatic key_req_t make_beat(input opcode_t op, input logic [7:0] b);
        key_req_t r;
        r.opcode    = op;
        r.scan_byte = b;
        return r;
    endfunction

    task automatic predict_beat(input key_req_t beat);
        key_rsp_t   rsp;
        logic [14:0] e;
        logic [6:0] code;
        logic [6:0] ch;
        logic       was_ext;
        rsp = '0;
        ch  = '0;
        if (beat.opcode == OP_READ)
        begin
            if (ring_wr != ring_rd)
            begin
                e             = key_ring[ring_rd];
                ring_rd       = (ring_rd + 1) % KEY_SLOTS;
                rsp.key_valid = 1'b1;
                rsp.key_code  = e[6:0];
                rsp.key_char  = e[13:7];
                rsp.key_down  = e[14];
            end
            rsp.more_keys = (ring_wr != ring_rd);
            expected_keys.push_back(rsp);
        end
        else if (beat.scan_byte == SC_EXTENDED)
        begin
            ext_armed = 1'b1;
        end
        else if (beat.scan_byte == SC_PAUSE)
        begin
            ext_armed = 1'b0;
        end
        else
        begin
            code      = beat.scan_byte[6:0] & SC_CODE_MASK;
            was_ext   = ext_armed;
            ext_armed = 1'b0;
            if ((beat.scan_byte & SC_RELEASE) == 8'h00)
            begin
                if (was_ext)
                begin
                    case (code)
                        SC_UP:    ch = CH_UP;
                        SC_DOWN:  ch = CH_DOWN;
                        SC_LEFT:  ch = CH_LEFT;
                        SC_RIGHT: ch = CH_RIGHT;
                        default:  ch = '0;
                    endcase
                end
                else if (code < MAP_LEN)
                begin
                    ch = ASCII_MAP[code][6:0];
                end
                if (ch != '0 && ((ring_wr + 1) % KEY_SLOTS) != ring_rd)
                begin
                    key_ring[ring_wr] = {1'b1, ch, code};
                    ring_wr           = (ring_wr + 1) % KEY_SLOTS;
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        key_rsp_t want;
        if (rst_n && done)
        begin
            if (expected_keys.size() == 0)
            begin
                report_mismatch("unexpected result", result, 0);
            end
            else
            begin
                want = expected_keys.pop_front();
                if (result.key_valid !== want.key_valid)
                    report_mismatch("key_valid", result.key_valid, want.key_valid);
                if (result.key_code !== want.key_code)
                    report_mismatch("key_code", result.key_code, want.key_code);
                if (result.key_char !== want.key_char)
                    report_mismatch("key_char", result.key_char, want.key_char);
                if (result.key_down !== want.key_down)
                    report_mismatch("key_down", result.key_down, want.key_down);
                if (result.more_keys !== want.more_keys)
                    report_mismatch("more_keys", result.more_keys, want.more_keys);
            end
        end
    end

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_beat(input key_req_t beat);
        start <= 1'b1;
        cmd   <= beat;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_beat(beat);
        beats_sent++;
        if (gaps_on && $urandom_range(0, 3) == 0)
            idle_cycles($urandom_range(1, 6));
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_beat(make_beat(OP_BYTE, b));
    endtask

    task automatic send_read();
        send_beat(make_beat(OP_READ, 8'($urandom_range(0, 255))));
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        @(posedge clk);
        while (expected_keys.size() != 0) @(posedge clk);
    endtask

    function automatic logic [6:0] pick_arrow();
        case ($urandom_range(0, 3))
            0:       return SC_UP;
            1:       return SC_DOWN;
            2:       return SC_LEFT;
            default: return SC_RIGHT;
        endcase
    endfunction

    task automatic test_directed();
        send_beat(make_beat(OP_READ, 8'h00));
        send_beat(make_beat(OP_READ, 8'hFF));
        send_byte(8'h02);
        send_byte(8'h39);
        send_byte(8'h3A);
        send_byte(8'h7F);
        send_byte(8'h00);
        send_byte(8'h1D);
        send_byte(8'h82);
        send_byte(SC_EXTENDED);
        send_byte({1'b0, SC_UP});
        send_byte(SC_EXTENDED);
        send_byte(SC_EXTENDED);
        send_byte({1'b0, SC_DOWN});
        send_byte(SC_EXTENDED);
        send_byte(SC_RELEASE | {1'b0, SC_LEFT});
        send_byte({1'b0, SC_LEFT});
        send_byte(SC_EXTENDED);
        send_byte(8'h1E);
        send_byte(SC_EXTENDED);
        send_byte(SC_PAUSE);
        send_byte(8'h1E);
        repeat (6) send_read();
    endtask

    task automatic test_queue_overflow();
        repeat (KEY_SLOTS + 4) send_byte(8'($urandom_range(2, 13)));
        send_byte(SC_EXTENDED);
        send_byte({1'b0, pick_arrow()});
        repeat (KEY_SLOTS + 1) send_read();
    endtask

    task automatic test_drain_pause();
        repeat (6) send_byte(8'($urandom_range(16, 25)));
        send_read();
        wait_drain();
        repeat (5) send_read();
        wait_drain();
        send_byte(SC_EXTENDED);
        send_byte({1'b0, pick_arrow()});
        send_read();
    endtask

    task automatic test_random_mix(input int count, input int read_pct);
        int          stop_at;
        int          r;
        logic [6:0]  code;
        stop_at = beats_sent + count;
        while (beats_sent < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < read_pct)
            begin
                send_read();
            end
            else if (r < read_pct + 35)
            begin
                code = 7'($urandom_range(0, 60));
                send_byte({1'b0, code});
                if ($urandom_range(0, 9) < 7)
                    send_byte(SC_RELEASE | {1'b0, code});
            end
            else if (r < read_pct + 50)
            begin
                code = ($urandom_range(0, 4) != 0) ? pick_arrow() : 7'($urandom_range(0, 127));
                send_byte(SC_EXTENDED);
                send_byte({1'b0, code});
                if ($urandom_range(0, 1) == 1)
                begin
                    send_byte(SC_EXTENDED);
                    send_byte(SC_RELEASE | {1'b0, code});
                end
            end
            else if (r < read_pct + 60)
            begin
                send_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                send_byte(SC_EXTENDED);
                if ($urandom_range(0, 1) == 1)
                    send_byte(SC_PAUSE);
                else
                    send_byte(SC_EXTENDED);
                send_byte($urandom_range(0, 1) ? {1'b0, pick_arrow()}
                                               : 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin
        ring_wr     = 0;
        ring_rd     = 0;
        ext_armed   = 1'b0;
        error_count = 0;
        beats_sent  = 0;
        gaps_on     = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_queue_overflow();
        test_drain_pause();
        test_random_mix(300, 30);
        test_random_mix(150, 20);
        test_random_mix(170, 45);
        gaps_on = 1'b0;
        test_random_mix(90, 30);

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
hdl/sckq_pkg.sv
hdl/sckq_ram.sv
hdl/sckq_front.sv
hdl/sckq_cmdq.sv
hdl/sckq_back.sv
hdl/scancode_to_key_queue.sv
tb/sv/tb_scancode_to_key_queue.sv
